[rtl/swb_pkg.sv]
// Shared types and constants for the subtract-with-borrow generator.
// Holds the transaction structs, operation codes and the seed arithmetic.
// No dependencies.
`default_nettype none
package swb_pkg;

	localparam int RING      = 24;
	localparam int SHORT_LAG = 10;
	localparam int BATCH_DEF = 100;

	localparam logic [30:0] RESET_SEED = 31'd314159265;
	localparam logic [30:0] LCG_MOD    = 31'd2147483563;
	localparam logic [15:0] LCG_MUL    = 16'd40014;
	localparam logic [6:0]  MOD_FOLD   = 7'd85;

	localparam logic [1:0] OP_DRAW  = 2'd0;
	localparam logic [1:0] OP_SEED  = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;
	localparam logic [1:0] OP_WRITE = 2'd3;

	localparam logic KIND_RANDOM = 1'b0;
	localparam logic KIND_STATE  = 1'b1;

	typedef struct packed {
		logic [1:0]  operation;
		logic [30:0] seed_value;
		logic [4:0]  word_index;
		logic [23:0] word_value;
		logic [4:0]  long_pos_in;
		logic [4:0]  short_pos_in;
		logic        carry_in;
	} swb_cmd_t;

	typedef struct packed {
		logic        result_kind;
		logic [23:0] random_value;
		logic [23:0] state_word;
		logic [4:0]  long_pos_out;
		logic [4:0]  short_pos_out;
		logic        carry_out;
	} swb_res_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [30:0] seed;
		logic [4:0]  idx;
		logic        idx_ring;
		logic        idx_ctl;
		logic [23:0] word;
		logic [4:0]  long_pos;
		logic [4:0]  short_pos;
		logic        carry;
	} swb_entry_t;

	typedef struct packed {
		logic pop;
	} swb_queue_ctl_t;

	function automatic logic [4:0] clamp_pos(input logic [4:0] p);
		clamp_pos = (p == 5'd0 || p > 5'(RING)) ? 5'(RING) : p;
	endfunction

	// Reduces a product below 2^47 modulo 2^31 - 85.
	function automatic logic [30:0] lcg_reduce(input logic [46:0] prod);
		logic [31:0] sum;
		sum = {1'b0, prod[30:0]} + (32'(prod[46:31]) * 32'(MOD_FOLD));
		if (sum >= {1'b0, LCG_MOD}) begin
			sum = sum - {1'b0, LCG_MOD};
		end
		lcg_reduce = sum[30:0];
	endfunction

endpackage
`default_nettype wire

[rtl/swb_front.sv]
// Front end of the generator: accepts transactions, decodes them and queues them.
// Depends on swb_pkg.
`default_nettype none
module swb_front (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    start,
	output logic                   busy,
	input  swb_pkg::swb_cmd_t      cmd,
	input  swb_pkg::swb_queue_ctl_t qctl_in,
	output logic                   q_valid,
	output swb_pkg::swb_entry_t    q_head
);
	import swb_pkg::*;

	swb_entry_t slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	swb_entry_t ent;
	logic       push;

	always_comb begin
		ent.op        = cmd.operation;
		ent.seed      = cmd.seed_value;
		ent.idx       = cmd.word_index;
		ent.idx_ring  = cmd.word_index < 5'(RING);
		ent.idx_ctl   = cmd.word_index == 5'(RING);
		ent.word      = cmd.word_value;
		ent.long_pos  = clamp_pos(cmd.long_pos_in);
		ent.short_pos = clamp_pos(cmd.short_pos_in);
		ent.carry     = cmd.carry_in;
	end

	assign busy    = count_q == 2'd2;
	assign push    = start && !busy;
	assign q_valid = count_q != 2'd0;
	assign q_head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (qctl_in.pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(qctl_in.pop);
		end
	end

endmodule
`default_nettype wire

[rtl/swb_back.sv]
// Back end of the generator: executes queued transactions on the lag ring and batch.
// Holds both memories and the sequencer. Depends on swb_pkg.
`default_nettype none
module swb_back #(
	parameter int BATCH = swb_pkg::BATCH_DEF
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire  [30:0]             default_seed,
	input  wire                     q_valid,
	input  swb_pkg::swb_entry_t     q_head,
	output swb_pkg::swb_queue_ctl_t qctl,
	output logic                    done,
	output swb_pkg::swb_res_t       result
);
	import swb_pkg::*;

	localparam int BW = (BATCH > 1) ? $clog2(BATCH) : 1;
	localparam int LW = $clog2(BATCH + 1);

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_MUL    = 8'b0000_0010,
		S_RED    = 8'b0000_0100,
		S_STEP_A = 8'b0000_1000,
		S_STEP_B = 8'b0001_0000,
		S_DRAW   = 8'b0010_0000,
		S_DOUT   = 8'b0100_0000,
		S_RDOUT  = 8'b1000_0000
	} state_t;

	state_t      state_q;
	logic [1:0]  op_q;
	logic        idx_ring_q;
	logic [30:0] s_q;
	logic [46:0] prod_q;
	logic [4:0]  i_q;
	logic [23:0] w13_q;
	logic [4:0]  long_q;
	logic [4:0]  short_q;
	logic        borrow_q;
	logic        seeded_q;
	logic [LW-1:0] left_q;
	logic [BW-1:0] cnt_q;
	logic [4:0]  wa_q;

	logic [23:0] ring_mem [RING];
	logic [23:0] batch_mem [BATCH];
	logic [23:0] ring_a_q;
	logic [23:0] ring_b_q;
	logic [23:0] batch_rd_q;

	logic        ring_we;
	logic [4:0]  ring_wa;
	logic [23:0] ring_wd;
	logic [4:0]  ring_ra;
	logic [4:0]  ring_rb;
	logic [BW-1:0] batch_ra;
	logic [4:0]  sp;
	logic [4:0]  lp;
	logic [30:0] s_new;
	logic [24:0] diff;
	logic        dispatch;

	assign sp       = short_q - 5'd1;
	assign lp       = long_q - 5'd1;
	assign s_new    = lcg_reduce(prod_q);
	assign diff     = {1'b0, ring_a_q} - {1'b0, ring_b_q} - 25'(borrow_q);
	assign dispatch = (state_q == S_IDLE) && q_valid;
	assign qctl.pop = dispatch;
	assign batch_ra = BW'(left_q - LW'(1));

	always_comb begin
		ring_we = 1'b0;
		ring_wa = q_head.idx;
		ring_wd = q_head.word;
		ring_ra = q_head.idx;
		ring_rb = lp;
		case (state_q)
			S_IDLE: begin
				ring_we = dispatch && q_head.op == OP_WRITE && q_head.idx_ring;
			end
			S_RED: begin
				ring_we = 1'b1;
				ring_wa = i_q;
				ring_wd = s_new[23:0];
			end
			S_STEP_A: begin
				ring_ra = sp;
			end
			S_STEP_B: begin
				ring_we = 1'b1;
				ring_wa = wa_q;
				ring_wd = diff[23:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_mem[ring_wa] <= ring_wd;
		end
		ring_a_q <= ring_mem[ring_ra];
		ring_b_q <= ring_mem[ring_rb];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_STEP_B) begin
			batch_mem[cnt_q] <= diff[23:0];
		end
		batch_rd_q <= batch_mem[batch_ra];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_MUL) begin
			prod_q <= 47'(s_q) * 47'(LCG_MUL);
		end
		if (state_q == S_RED && i_q == 5'd13) begin
			w13_q <= s_new[23:0];
		end
		if (state_q == S_STEP_A) begin
			wa_q <= lp;
		end
		if (dispatch) begin
			op_q       <= q_head.op;
			idx_ring_q <= q_head.idx_ring;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			s_q      <= '0;
			i_q      <= '0;
			long_q   <= 5'(RING);
			short_q  <= 5'(SHORT_LAG);
			borrow_q <= 1'b0;
			seeded_q <= 1'b0;
			left_q   <= '0;
			cnt_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (dispatch) begin
						case (q_head.op)
							OP_SEED: begin
								s_q     <= (q_head.seed != '0) ? q_head.seed : default_seed;
								i_q     <= '0;
								state_q <= S_MUL;
							end
							OP_WRITE: begin
								if (q_head.idx_ctl) begin
									long_q   <= q_head.long_pos;
									short_q  <= q_head.short_pos;
									borrow_q <= q_head.carry;
									seeded_q <= 1'b1;
								end
							end
							OP_READ: begin
								state_q <= S_RDOUT;
							end
							default: begin
								if (left_q != '0) begin
									left_q  <= left_q - LW'(1);
									state_q <= S_DOUT;
								end else if (!seeded_q) begin
									s_q     <= default_seed;
									i_q     <= '0;
									state_q <= S_MUL;
								end else begin
									cnt_q   <= '0;
									state_q <= S_STEP_A;
								end
							end
						endcase
					end
				end
				S_MUL: begin
					state_q <= S_RED;
				end
				S_RED: begin
					s_q <= s_new;
					if (i_q == 5'(RING - 1)) begin
						borrow_q <= s_new[23:0] < w13_q;
						long_q   <= 5'(RING);
						short_q  <= 5'(SHORT_LAG);
						left_q   <= '0;
						seeded_q <= 1'b1;
						cnt_q    <= '0;
						state_q  <= (op_q == OP_DRAW) ? S_STEP_A : S_IDLE;
					end else begin
						i_q     <= i_q + 5'd1;
						state_q <= S_MUL;
					end
				end
				S_STEP_A: begin
					short_q <= (sp == 5'd0) ? 5'(RING) : sp;
					long_q  <= (lp == 5'd0) ? 5'(RING) : lp;
					state_q <= S_STEP_B;
				end
				S_STEP_B: begin
					borrow_q <= diff[24];
					if (cnt_q == BW'(BATCH - 1)) begin
						left_q  <= LW'(BATCH);
						state_q <= S_DRAW;
					end else begin
						cnt_q   <= cnt_q + BW'(1);
						state_q <= S_STEP_A;
					end
				end
				S_DRAW: begin
					left_q  <= left_q - LW'(1);
					state_q <= S_DOUT;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		done   = (state_q == S_DOUT) || (state_q == S_RDOUT);
		result = '0;
		if (state_q == S_DOUT) begin
			result.result_kind  = KIND_RANDOM;
			result.random_value = batch_rd_q;
		end else if (state_q == S_RDOUT) begin
			result.result_kind   = KIND_STATE;
			result.state_word    = idx_ring_q ? ring_a_q : 24'd0;
			result.long_pos_out  = long_q;
			result.short_pos_out = short_q;
			result.carry_out     = borrow_q;
		end
	end

endmodule
`default_nettype wire

[rtl/subtract_with_borrow_rng_unit.sv]
// A draw from a filled batch gives its result from the batch memory; a read gives a ring word,
// the lag positions and the borrow. An empty batch is refilled first, each ring step a read
// state then a write state of the ring memory; seeding fills the 24 ring words by multiply
// and reduce states. Seed and write transactions give no result. A two-entry queue takes new
// transactions while work runs. Reset clears control state, not the ring and batch memories.
`default_nettype none
module subtract_with_borrow_rng_unit #(
	parameter int BATCH = swb_pkg::BATCH_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	output logic               busy,
	input  swb_pkg::swb_cmd_t  cmd,
	output logic               done,
	output swb_pkg::swb_res_t  result,
	input  wire                psel,
	input  wire                penable,
	input  wire                pwrite,
	input  wire  [1:0]         paddr,
	input  wire  [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import swb_pkg::*;

	logic [30:0]    default_seed_q;
	logic           q_valid;
	swb_entry_t     q_head;
	swb_queue_ctl_t qctl;

	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? {1'b0, default_seed_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_seed_q <= RESET_SEED;
		end else if (psel && penable && pwrite && paddr == 2'd0) begin
			default_seed_q <= pwdata[30:0];
		end
	end

	swb_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.cmd     (cmd),
		.qctl_in (qctl),
		.q_valid (q_valid),
		.q_head  (q_head)
	);

	swb_back #(.BATCH(BATCH)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.default_seed (default_seed_q),
		.q_valid      (q_valid),
		.q_head       (q_head),
		.qctl         (qctl),
		.done         (done),
		.result       (result)
	);

`ifndef NO_ASSERTIONS
	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("back-to-back result strobes");
	a_read_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.result_kind == KIND_STATE) |->
		(result.long_pos_out != 5'd0 && result.long_pos_out <= 5'd24 &&
		 result.short_pos_out != 5'd0 && result.short_pos_out <= 5'd24))
		else $error("lag position out of range");
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		qctl.pop |-> q_valid) else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire
